@@ design/sbc_pkg.sv @@
// Package for the sphere/box collision pipeline.
// Register codes, reset values and shared widths; no dependencies.
package sbc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int REG_W    = 23;
  localparam int RAD_W    = 16;
  localparam int COEF_W   = 16;
  localparam int K_W      = 17;   // 32768 + bounce_coef
  localparam int D_W      = 17;   // box-to-centre offset, signed
  localparam int N_W      = 18;   // normal component, signed Q.16
  localparam int SQ_W     = 32;   // radicand of the distance root
  localparam int ROOT_W   = 16;
  localparam int QUO_W    = 17;
  localparam int IDX_W    = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_X_HALF     = 8'd0,
    REG_BASE_Y     = 8'd1,
    REG_HEIGHT     = 8'd2,
    REG_HALF_THICK = 8'd3
  } reg_idx_t;

  localparam logic [REG_W-1:0] X_HALF_RST     = 23'd50000;
  localparam logic [REG_W-1:0] BASE_Y_RST     = 23'd50000;
  localparam logic [REG_W-1:0] HEIGHT_RST     = 23'd10000;
  localparam logic [REG_W-1:0] HALF_THICK_RST = 23'd300;

  localparam logic signed [N_W-1:0] N_ONE = 18'sd65536;

  typedef struct packed {
    logic [REG_W-1:0] x_half;
    logic [REG_W-1:0] base_y;
    logic [REG_W-1:0] height;
    logic [REG_W-1:0] half_thick;
  } box_cfg_t;

  typedef struct packed {
    logic en;    // whole pipeline advances
    logic vld;   // beat entering this section
  } pipe_ctl_t;

endpackage

@@ design/sphere_box_collision_response.sv @@
// Top level of the sphere versus box collision pipeline.
// Instantiates sbc_front, sbc_sqrt, sbc_div and sbc_resp; uses sbc_pkg.
//
// Usage:
//   in_*  : one query beat per sphere (position, velocity, radius, restitution).
//   out_* : one result beat per query, in order; out_tuser is the hit flag.
//   cfg_* : box register writes (index 0..3), always ready; write them only
//           while no query is in flight. Indices above 3 are dropped.
// Pipeline: 3 front stages + 16 square-root stages + 17 divider stages
//   + 8 response stages from an accepted input beat to out_tvalid.
// Throughput: one beat per cycle unless the output stalls. The whole pipeline
//   advances together; a beat enters whenever the output register is empty or being taken.
// Stall: while out_tvalid is high and out_tready low, every stage holds and
//   in_tready is low; no beat is lost or repeated, bubbles stay in place.
// Reset: rst_n (synchronous, active low) empties the pipeline and loads the
//   box registers with their reset values (half width 50000, base 50000,
//   height 10000, half thickness 300, all Q7.16).
module sphere_box_collision_response import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, sphere_radius, bounce_coef
  input  logic [((6*COORD_BITS+2*RAD_W+7)/8)*8-1:0] in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [((6*COORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic                  out_tuser,   // hit
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int W    = COORD_BITS;
  localparam int OTW  = ((6*W+7)/8)*8;
  localparam int S1_W = 6*W + RAD_W + K_W + 2 + 3*D_W + 3*N_W;
  localparam int S2_W = S1_W + ROOT_W;
  localparam int OFS_FLAGS = ROOT_W + 3*N_W + 3*D_W;   // inside flag, then hit

  // box registers
  box_cfg_t cfg_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_half     <= X_HALF_RST;
      cfg_r.base_y     <= BASE_Y_RST;
      cfg_r.height     <= HEIGHT_RST;
      cfg_r.half_thick <= HALF_THICK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_HALF:     cfg_r.x_half     <= cfg_data;
        REG_BASE_Y:     cfg_r.base_y     <= cfg_data;
        REG_HEIGHT:     cfg_r.height     <= cfg_data;
        REG_HALF_THICK: cfg_r.half_thick <= cfg_data;
        default:        cfg_r <= cfg_r;
      endcase
    end
  end

  // one enable for all stages: advance when the output register frees up
  logic      en, out_vld;
  pipe_ctl_t ctl_front, ctl_sqrt, ctl_div, ctl_resp;
  assign en        = !out_vld || out_tready;
  assign in_tready = en;

  // front
  logic               f_vld, f_hit, f_inside;
  logic [3*W-1:0]     f_pos, f_vel;
  logic [RAD_W-1:0]   f_rad;
  logic [K_W-1:0]     f_k;
  logic [3*D_W-1:0]   f_d;
  logic [3*N_W-1:0]   f_nin;
  logic [SQ_W-1:0]    f_dist2;

  assign ctl_front = '{en: en, vld: in_tvalid};

  sbc_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_front),
    .cfg      (cfg_r),
    .pos      (in_tdata[3*W-1:0]),
    .vel      (in_tdata[6*W-1:3*W]),
    .rad      (in_tdata[6*W +: RAD_W]),
    .coef     (in_tdata[6*W+RAD_W +: COEF_W]),
    .vld_o    (f_vld),
    .pos_o    (f_pos),
    .vel_o    (f_vel),
    .rad_o    (f_rad),
    .k_o      (f_k),
    .hit_o    (f_hit),
    .inside_o (f_inside),
    .d_o      (f_d),
    .nin_o    (f_nin),
    .dist2_o  (f_dist2)
  );

  // square root
  logic              q_vld;
  logic [ROOT_W-1:0] q_root;
  logic [S1_W-1:0]   side1, q_side;
  assign side1    = {f_pos, f_vel, f_rad, f_k, f_hit, f_inside, f_d, f_nin};
  assign ctl_sqrt = '{en: en, vld: f_vld};

  sbc_sqrt #(.SIDE_W(S1_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_sqrt),
    .rad_in  (f_dist2),
    .side_in (side1),
    .vld_o   (q_vld),
    .root_o  (q_root),
    .side_o  (q_side)
  );

  // divider
  logic [3*D_W-1:0]   q_d;
  logic               v_vld;
  logic [3*QUO_W-1:0] v_quo;
  logic [2:0]         v_neg;
  logic [S2_W-1:0]    side2, v_side;
  assign q_d     = q_side[3*N_W +: 3*D_W];
  assign side2   = {q_side, q_root};
  assign ctl_div = '{en: en, vld: q_vld};

  sbc_div #(.SIDE_W(S2_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_div),
    .d_in    (q_d),
    .divisor (q_root),
    .side_in (side2),
    .vld_o   (v_vld),
    .quo_o   (v_quo),
    .neg_o   (v_neg),
    .side_o  (v_side)
  );

  // unpack the carried fields for the response; the offsets are done with
  logic [3*W-1:0]     r_pos, r_vel;
  logic [RAD_W-1:0]   r_rad;
  logic [K_W-1:0]     r_k;
  logic               r_hit, r_inside;
  logic [3*N_W-1:0]   r_nin;
  logic [ROOT_W-1:0]  r_dist;
  assign r_dist   = v_side[ROOT_W-1:0];
  assign r_nin    = v_side[ROOT_W +: 3*N_W];
  assign r_inside = v_side[OFS_FLAGS];
  assign r_hit    = v_side[OFS_FLAGS+1];
  assign r_k      = v_side[OFS_FLAGS+2 +: K_W];
  assign r_rad    = v_side[OFS_FLAGS+2+K_W +: RAD_W];
  assign r_vel    = v_side[S2_W-6*W +: 3*W];
  assign r_pos    = v_side[S2_W-3*W +: 3*W];
  assign ctl_resp = '{en: en, vld: v_vld};

  logic           o_hit;
  logic [3*W-1:0] o_pos, o_vel;

  sbc_resp #(.W(W)) u_resp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl_resp),
    .hit        (r_hit),
    .ctr_in_box (r_inside),
    .nin        (r_nin),
    .quo        (v_quo),
    .qneg       (v_neg),
    .root_dist  (r_dist),
    .pos        (r_pos),
    .vel        (r_vel),
    .rad        (r_rad),
    .k          (r_k),
    .vld_o      (out_vld),
    .hit_o      (o_hit),
    .pos_o      (o_pos),
    .vel_o      (o_vel)
  );

  assign out_tvalid = out_vld;
  assign out_tuser  = o_hit;
  assign out_tdata  = OTW'({o_vel, o_pos});

endmodule

@@ design/sbc_front.sv @@
// Front section: box reject, offset to box, squared distance, inside normal.
// Three register stages; uses sbc_pkg.
module sbc_front import sbc_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctl_t            ctl,
  input  box_cfg_t             cfg,
  input  logic [3*W-1:0]       pos,
  input  logic [3*W-1:0]       vel,
  input  logic [RAD_W-1:0]     rad,
  input  logic [COEF_W-1:0]    coef,
  output logic                 vld_o,
  output logic [3*W-1:0]       pos_o,
  output logic [3*W-1:0]       vel_o,
  output logic [RAD_W-1:0]     rad_o,
  output logic [K_W-1:0]       k_o,
  output logic                 hit_o,
  output logic                 inside_o,
  output logic [3*D_W-1:0]     d_o,
  output logic [3*N_W-1:0]     nin_o,
  output logic [SQ_W-1:0]      dist2_o
);

  localparam int CW = ((W > 25) ? W : 25) + 3;

  // stage 1
  logic                  s1_vld_r, s2_vld_r, s3_vld_r;
  logic [3*W-1:0]        s1_pos_r, s2_pos_r, s3_pos_r;
  logic [3*W-1:0]        s1_vel_r, s2_vel_r, s3_vel_r;
  logic [RAD_W-1:0]      s1_rad_r, s2_rad_r, s3_rad_r;
  logic [K_W-1:0]        s1_k_r, s2_k_r, s3_k_r;
  logic                  s1_hit_r, s2_hit_r, s3_hit_r, s3_inside_r;
  logic [3*D_W-1:0]      s1_d_r, s2_d_r, s3_d_r;
  logic signed [CW-1:0]  s1_pen_r [3];
  logic [2:0]            s1_neg_r;
  logic [3*N_W-1:0]      s2_nin_r, s3_nin_r;
  logic [2*D_W-1:0]      s2_sq_r [3];
  logic [SQ_W-1:0]       s2_rr_r, s3_dist2_r;

  logic signed [CW-1:0]  pe [3];
  logic signed [CW-1:0]  lo [3];
  logic signed [CW-1:0]  hi [3];
  logic signed [CW-1:0]  cl [3];
  logic signed [CW-1:0]  dd [3];
  logic signed [CW-1:0]  re, hw_e, y0_e, h_e, ht_e, ty, ay, ax, az;
  logic                  hit1_nxt;
  logic [3*D_W-1:0]      d1_nxt;
  logic signed [CW-1:0]  pen_nxt [3];
  logic [2:0]            neg_nxt;

  always_comb begin
    re   = $signed({{(CW-RAD_W){1'b0}}, rad});
    hw_e = $signed({{(CW-REG_W){1'b0}}, cfg.x_half});
    y0_e = $signed({{(CW-REG_W){1'b0}}, cfg.base_y});
    h_e  = $signed({{(CW-REG_W){1'b0}}, cfg.height});
    ht_e = $signed({{(CW-REG_W){1'b0}}, cfg.half_thick});
    lo[0] = -hw_e;  hi[0] = hw_e;
    lo[1] = y0_e;   hi[1] = y0_e + h_e;
    lo[2] = -ht_e;  hi[2] = ht_e;
    hit1_nxt = 1'b1;
    d1_nxt   = '0;
    for (int i = 0; i < 3; i++) begin
      pe[i] = $signed({{(CW-W){pos[i*W+W-1]}}, pos[i*W +: W]});
      if ((pe[i] + re < lo[i]) || (pe[i] - re > hi[i])) hit1_nxt = 1'b0;
      cl[i] = (pe[i] < lo[i]) ? lo[i] : ((pe[i] > hi[i]) ? hi[i] : pe[i]);
      dd[i] = pe[i] - cl[i];
      d1_nxt[i*D_W +: D_W] = dd[i][D_W-1:0];
    end
    ax = pe[0][CW-1] ? -pe[0] : pe[0];
    az = pe[2][CW-1] ? -pe[2] : pe[2];
    ty = (pe[1] <<< 1) - (y0_e <<< 1) - h_e;
    ay = ty[CW-1] ? -ty : ty;
    pen_nxt[0] = (hw_e <<< 1) - (ax <<< 1);
    pen_nxt[1] = h_e - ay;
    pen_nxt[2] = (ht_e <<< 1) - (az <<< 1);
    neg_nxt[0] = pe[0][CW-1];
    neg_nxt[1] = ty[CW-1];
    neg_nxt[2] = pe[2][CW-1];
  end

  // stage 2: squares and face choice
  logic [3*N_W-1:0]      nin_nxt;
  logic signed [2*D_W-1:0] sq_nxt [3];
  always_comb begin
    nin_nxt = '0;
    if ((s1_pen_r[2] <= s1_pen_r[0]) && (s1_pen_r[2] <= s1_pen_r[1]))
      nin_nxt[2*N_W +: N_W] = s1_neg_r[2] ? -N_ONE : N_ONE;
    else if (s1_pen_r[0] <= s1_pen_r[1])
      nin_nxt[0 +: N_W] = s1_neg_r[0] ? -N_ONE : N_ONE;
    else
      nin_nxt[N_W +: N_W] = s1_neg_r[1] ? -N_ONE : N_ONE;
    for (int i = 0; i < 3; i++)
      sq_nxt[i] = $signed(s1_d_r[i*D_W +: D_W]) * $signed(s1_d_r[i*D_W +: D_W]);
  end

  // stage 3: distance test
  logic [2*D_W:0] dist2_nxt;
  always_comb begin
    dist2_nxt = {1'b0, s2_sq_r[0]} + {1'b0, s2_sq_r[1]} + {1'b0, s2_sq_r[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (ctl.en) begin
      s1_vld_r <= ctl.vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      s1_pos_r <= pos;
      s1_vel_r <= vel;
      s1_rad_r <= rad;
      s1_k_r   <= K_W'(32768) + K_W'(coef);
      s1_hit_r <= hit1_nxt;
      s1_d_r   <= d1_nxt;
      s1_neg_r <= neg_nxt;
      for (int i = 0; i < 3; i++) s1_pen_r[i] <= pen_nxt[i];

      s2_pos_r <= s1_pos_r;
      s2_vel_r <= s1_vel_r;
      s2_rad_r <= s1_rad_r;
      s2_k_r   <= s1_k_r;
      s2_hit_r <= s1_hit_r;
      s2_d_r   <= s1_d_r;
      s2_nin_r <= nin_nxt;
      s2_rr_r  <= s1_rad_r * s1_rad_r;
      for (int i = 0; i < 3; i++) s2_sq_r[i] <= sq_nxt[i];

      s3_pos_r    <= s2_pos_r;
      s3_vel_r    <= s2_vel_r;
      s3_rad_r    <= s2_rad_r;
      s3_k_r      <= s2_k_r;
      s3_hit_r    <= s2_hit_r && (dist2_nxt < {3'b000, s2_rr_r});
      s3_inside_r <= (dist2_nxt == '0);
      s3_d_r      <= s2_d_r;
      s3_nin_r    <= s2_nin_r;
      s3_dist2_r  <= dist2_nxt[SQ_W-1:0];
    end
  end

  assign vld_o    = s3_vld_r;
  assign pos_o    = s3_pos_r;
  assign vel_o    = s3_vel_r;
  assign rad_o    = s3_rad_r;
  assign k_o      = s3_k_r;
  assign hit_o    = s3_hit_r;
  assign inside_o = s3_inside_r;
  assign d_o      = s3_d_r;
  assign nin_o    = s3_nin_r;
  assign dist2_o  = s3_dist2_r;

endmodule

@@ design/sbc_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Carries a side payload alongside; uses sbc_pkg.
module sbc_sqrt import sbc_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  logic [SQ_W-1:0]   rad_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int RW = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SQ_W-1:0]   rad_r  [ROOT_W];
  logic [SIDE_W-1:0] side_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic              vld_i;
    logic [RW-1:0]     rem_i, remsh, trial, rem_nxt;
    logic [ROOT_W-1:0] root_i, root_nxt;
    logic [SQ_W-1:0]   rad_i;
    logic [SIDE_W-1:0] side_i;

    if (g == 0) begin : g_first
      assign vld_i  = ctl.vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad_in;
      assign side_i = side_in;
    end else begin : g_next
      assign vld_i  = vld_r[g-1];
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign rad_i  = rad_r[g-1];
      assign side_i = side_r[g-1];
    end

    always_comb begin
      remsh = {rem_i[RW-3:0], rad_i[SQ_W-1 -: 2]};
      trial = {root_i, 2'b01};
      if (remsh >= trial) begin
        rem_nxt  = remsh - trial;
        root_nxt = {root_i[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = remsh;
        root_nxt = {root_i[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g] <= 1'b0;
      else if (ctl.en) vld_r[g] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[g]  <= rem_nxt;
        root_r[g] <= root_nxt;
        rad_r[g]  <= {rad_i[SQ_W-3:0], 2'b00};
        side_r[g] <= side_i;
      end
    end
  end

  assign vld_o  = vld_r[ROOT_W-1];
  assign root_o = root_r[ROOT_W-1];
  assign side_o = side_r[ROOT_W-1];

endmodule

@@ design/sbc_div.sv @@
// Pipelined three-lane restoring divider for the normal: |d|*2^16 / dist.
// One quotient bit per stage; quotient magnitude and sign out. Uses sbc_pkg.
module sbc_div import sbc_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_ctl_t         ctl,
  input  logic [3*D_W-1:0]  d_in,
  input  logic [ROOT_W-1:0] divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_o,
  output logic [3*QUO_W-1:0] quo_o,
  output logic [2:0]        neg_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int NS = QUO_W;

  logic              vld_r  [NS];
  logic [ROOT_W-1:0] rem_r  [NS][3];
  logic [QUO_W-1:0]  low_r  [NS][3];
  logic [QUO_W-1:0]  quo_r  [NS][3];
  logic [2:0]        neg_r  [NS];
  logic [ROOT_W-1:0] div_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic              vld_i;
    logic [ROOT_W-1:0] rem_i  [3];
    logic [QUO_W-1:0]  low_i  [3];
    logic [QUO_W-1:0]  quo_i  [3];
    logic [2:0]        neg_i;
    logic [ROOT_W-1:0] div_i;
    logic [SIDE_W-1:0] side_i;
    logic [ROOT_W:0]   remsh  [3];
    logic [ROOT_W-1:0] rem_nxt [3];
    logic [QUO_W-1:0]  quo_nxt [3];

    if (g == 0) begin : g_first
      logic [D_W-1:0] mag [3];
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          neg_i[l] = d_in[l*D_W + D_W-1];
          mag[l]   = neg_i[l] ? (~d_in[l*D_W +: D_W] + 1'b1) : d_in[l*D_W +: D_W];
          // top dividend bits start the remainder, the rest shift in
          rem_i[l] = mag[l][D_W-1:1];
          low_i[l] = {mag[l][0], {(QUO_W-1){1'b0}}};
          quo_i[l] = '0;
        end
      end
      assign vld_i  = ctl.vld;
      assign div_i  = divisor;
      assign side_i = side_in;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_i[l] = rem_r[g-1][l];
          low_i[l] = low_r[g-1][l];
          quo_i[l] = quo_r[g-1][l];
        end
      end
      assign vld_i  = vld_r[g-1];
      assign neg_i  = neg_r[g-1];
      assign div_i  = div_r[g-1];
      assign side_i = side_r[g-1];
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        remsh[l] = {rem_i[l], low_i[l][QUO_W-1]};
        if (remsh[l] >= {1'b0, div_i}) begin
          rem_nxt[l] = ROOT_W'(remsh[l] - {1'b0, div_i});
          quo_nxt[l] = {quo_i[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = remsh[l][ROOT_W-1:0];
          quo_nxt[l] = {quo_i[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g] <= 1'b0;
      else if (ctl.en) vld_r[g] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[g][l] <= rem_nxt[l];
          low_r[g][l] <= {low_i[l][QUO_W-2:0], 1'b0};
          quo_r[g][l] <= quo_nxt[l];
        end
        neg_r[g]  <= neg_i;
        div_r[g]  <= div_i;
        side_r[g] <= side_i;
      end
    end
  end

  assign vld_o  = vld_r[NS-1];
  assign quo_o  = {quo_r[NS-1][2], quo_r[NS-1][1], quo_r[NS-1][0]};
  assign neg_o  = neg_r[NS-1];
  assign side_o = side_r[NS-1];

endmodule

@@ design/sbc_resp.sv @@
// Response section: push-out, normal velocity, reflection, saturation.
// Eight register stages, the last one is the output register. Uses sbc_pkg.
module sbc_resp import sbc_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pipe_ctl_t          ctl,
  input  logic               hit,
  input  logic               ctr_in_box,
  input  logic [3*N_W-1:0]   nin,
  input  logic [3*QUO_W-1:0] quo,
  input  logic [2:0]         qneg,
  input  logic [ROOT_W-1:0]  root_dist,
  input  logic [3*W-1:0]     pos,
  input  logic [3*W-1:0]     vel,
  input  logic [RAD_W-1:0]   rad,
  input  logic [K_W-1:0]     k,
  output logic               vld_o,
  output logic               hit_o,
  output logic [3*W-1:0]     pos_o,
  output logic [3*W-1:0]     vel_o
);

  localparam int CRW = N_W + RAD_W + 1;     // push-out product
  localparam int PRW = W + N_W;             // velocity times normal
  localparam int DW  = PRW + 2;             // dot product
  localparam int VW  = DW - 15;             // rounded dot
  localparam int JPW = VW + K_W + 1;        // vn * k
  localparam int JW  = JPW - 14;            // rounded impulse
  localparam int MW  = JW + N_W;            // n * j
  localparam int XW  = MW + 2;              // working width for saturation

  localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    begin
      y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
      sat_w = y[W-1:0];
    end
  endfunction

  logic              vld_r [8];
  logic              hit_r [7];
  logic [3*W-1:0]    pos_r [2];
  logic [3*W-1:0]    vel_r [7];
  logic [K_W-1:0]    k_r   [4];
  logic signed [N_W-1:0] n_r [7][3];

  logic signed [RAD_W:0]  dd1_r;
  logic signed [CRW-1:0]  corr2_r [3];
  logic signed [PRW-1:0]  prod2_r [3];
  logic signed [DW-1:0]   dot3_r;
  logic [3*W-1:0]         np3_r, np4_r, np5_r, np6_r, np7_r;
  logic signed [VW-1:0]   vn4_r;
  logic                   neg4_r, neg5_r, neg6_r, neg7_r;
  logic signed [JPW-1:0]  jp5_r;
  logic signed [JW-1:0]   j6_r;
  logic signed [MW-1:0]   m7_r [3];
  logic                   hit8_r;
  logic [3*W-1:0]         pos8_r, vel8_r;

  // stage 1: pick the normal
  logic signed [N_W-1:0] n1_nxt [3];
  logic signed [N_W-1:0] qs;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs = $signed({1'b0, quo[i*QUO_W +: QUO_W]});
      n1_nxt[i] = ctr_in_box ? $signed(nin[i*N_W +: N_W]) : (qneg[i] ? -qs : qs);
    end
  end

  // stage 3: push-out and dot sum
  logic [3*W-1:0]        np3_nxt;
  logic signed [CRW:0]   cb;
  logic signed [XW-1:0]  pw;
  always_comb begin
    np3_nxt = pos_r[1];
    for (int i = 0; i < 3; i++) begin
      cb = {corr2_r[i][CRW-1], corr2_r[i]} + (CRW+1)'(32768);
      pw = XW'($signed(pos_r[1][i*W +: W])) + XW'($signed(cb[CRW:16]));
      if (hit_r[1]) np3_nxt[i*W +: W] = sat_w(pw);
    end
  end

  // stage 8: apply reflection
  logic [3*W-1:0]        nv8_nxt;
  logic signed [MW:0]    mb;
  logic signed [XW-1:0]  vw;
  always_comb begin
    nv8_nxt = vel_r[6];
    for (int i = 0; i < 3; i++) begin
      mb = {m7_r[i][MW-1], m7_r[i]} + (MW+1)'(32768);
      vw = XW'($signed(vel_r[6][i*W +: W])) - XW'($signed(mb[MW:16]));
      if (hit_r[6] && neg7_r) nv8_nxt[i*W +: W] = sat_w(vw);
    end
  end

  logic signed [DW:0]    db;
  logic signed [JPW:0]   jb;
  always_comb begin
    db = {dot3_r[DW-1], dot3_r} + (DW+1)'(32768);
    jb = {jp5_r[JPW-1], jp5_r} + (JPW+1)'(16384);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 8; s++) vld_r[s] <= 1'b0;
    end else if (ctl.en) begin
      vld_r[0] <= ctl.vld;
      for (int s = 1; s < 8; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      // hold line for per-item fields
      hit_r[0] <= hit;
      vel_r[0] <= vel;
      pos_r[0] <= pos;
      k_r[0]   <= k;
      for (int i = 0; i < 3; i++) n_r[0][i] <= n1_nxt[i];
      for (int s = 1; s < 7; s++) begin
        hit_r[s] <= hit_r[s-1];
        vel_r[s] <= vel_r[s-1];
        for (int i = 0; i < 3; i++) n_r[s][i] <= n_r[s-1][i];
      end
      pos_r[1] <= pos_r[0];
      for (int s = 1; s < 4; s++) k_r[s] <= k_r[s-1];
      dd1_r <= $signed({1'b0, rad}) - $signed({1'b0, root_dist});

      // stage 2
      for (int i = 0; i < 3; i++) begin
        corr2_r[i] <= n_r[0][i] * dd1_r;
        prod2_r[i] <= $signed(vel_r[0][i*W +: W]) * n_r[0][i];
      end

      // stage 3
      dot3_r <= DW'(prod2_r[0]) + DW'(prod2_r[1]) + DW'(prod2_r[2]);
      np3_r  <= np3_nxt;

      // stage 4
      vn4_r  <= db[DW:16];
      neg4_r <= dot3_r[DW-1];
      np4_r  <= np3_r;

      // stage 5
      jp5_r  <= vn4_r * $signed({1'b0, k_r[3]});
      neg5_r <= neg4_r;
      np5_r  <= np4_r;

      // stage 6
      j6_r   <= jb[JPW:15];
      neg6_r <= neg5_r;
      np6_r  <= np5_r;

      // stage 7
      for (int i = 0; i < 3; i++) m7_r[i] <= n_r[5][i] * j6_r;
      neg7_r <= neg6_r;
      np7_r  <= np6_r;

      // stage 8: output register
      hit8_r <= hit_r[6];
      pos8_r <= np7_r;
      vel8_r <= nv8_nxt;
    end
  end

  assign vld_o = vld_r[7];
  assign hit_o = hit8_r;
  assign pos_o = pos8_r;
  assign vel_o = vel8_r;

endmodule
